/* rtl/core/uvst_pkg.sv */
// Package: shared constants, types and tables for the UV sphere tessellator
`default_nettype none
package uvst_pkg;

  localparam int MaxSeg    = 1024;
  localparam int FracBits  = 16;
  localparam int CordSteps = 30;
  localparam int SegW      = 11;
  localparam int IdxW      = 11;
  localparam int RecipW    = 48;   // reciprocal fraction bits
  localparam logic signed [35:0] CordGain = 36'sd652032874;
  localparam logic signed [35:0] OneQ30   = 36'sd1073741824;

  typedef enum logic [2:0] {
    KIND_POS  = 3'd0,
    KIND_NRM  = 3'd1,
    KIND_TEX  = 3'd2,
    KIND_TAN  = 3'd3,
    KIND_BIT  = 3'd4,
    KIND_TRI  = 3'd5,
    KIND_ERR  = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    REG_RADIUS = 2'd0,
    REG_SECTOR = 2'd1,
    REG_STACK  = 2'd2
  } reg_idx_e;

  // arctangent of 2^-k in 2^-32 turns
  function automatic logic signed [33:0] atan_turn(input int k);
    logic signed [33:0] t;
    case (k)
      0: t = 34'sd536870912;   1: t = 34'sd316933406;   2: t = 34'sd167458907;
      3: t = 34'sd85004756;    4: t = 34'sd42667331;    5: t = 34'sd21354465;
      6: t = 34'sd10679838;    7: t = 34'sd5340245;     8: t = 34'sd2670163;
      9: t = 34'sd1335087;    10: t = 34'sd667544;     11: t = 34'sd333772;
      12: t = 34'sd166886;    13: t = 34'sd83443;      14: t = 34'sd41722;
      15: t = 34'sd20861;     16: t = 34'sd10430;      17: t = 34'sd5215;
      18: t = 34'sd2608;      19: t = 34'sd1304;       20: t = 34'sd652;
      21: t = 34'sd326;       22: t = 34'sd163;        23: t = 34'sd81;
      24: t = 34'sd41;        25: t = 34'sd20;         26: t = 34'sd10;
      27: t = 34'sd5;         28: t = 34'sd3;          29: t = 34'sd1;
      default: t = 34'sd0;
    endcase
    return t;
  endfunction

  // saturate a wide signed value into 32 bits
  function automatic logic [31:0] sat32(input logic signed [71:0] v);
    logic [31:0] r;
    if (v > 72'sd2147483647) r = 32'h7fff_ffff;
    else if (v < -72'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  // round by 2^s: floor((v + 2^(s-1)) / 2^s)
  function automatic logic signed [71:0] rnd(input logic signed [71:0] v, input int s);
    logic signed [71:0] one;
    one = 72'sd1;
    return (v + (one <<< (s - 1))) >>> s;
  endfunction

  typedef struct packed {
    logic        cmd;
    logic        err;
    logic [IdxW-1:0] i;
    logic [IdxW-1:0] j;
    logic [SegW-1:0] sec;
    logic [SegW-1:0] stk;
    logic [15:0] rad;
  } item_t;

endpackage
`default_nettype wire

/* rtl/core/uvst_divu.sv */
// Pipelined restoring divider: quotient of a 43-bit dividend by an 11-bit divisor
`default_nettype none
module uvst_divu import uvst_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [42:0] num_i,
  input  wire logic [SegW-1:0] den_i,
  output logic [42:0]      quo_o
);
  // one quotient bit per step, registered every NPer bits
  localparam int NBits = 43;
  localparam int NPer  = 8;
  localparam int NStg  = (NBits + NPer - 1) / NPer;

  logic [42:0]     num_q [NStg+1];
  logic [42:0]     quo_q [NStg+1];
  logic [SegW:0]   rem_q [NStg+1];
  logic [SegW-1:0] den_q [NStg+1];

  always_comb begin
    num_q[0] = num_i;
    quo_q[0] = '0;
    rem_q[0] = '0;
    den_q[0] = den_i;
  end

  for (genvar s = 0; s < NStg; s++) begin : g_stg
    logic [42:0]   n_d, q_d;
    logic [SegW:0] r_d;
    always_comb begin
      logic [SegW+1:0] t;
      n_d = num_q[s];
      q_d = quo_q[s];
      r_d = rem_q[s];
      for (int b = 0; b < NPer; b++) begin
        if (s * NPer + b < NBits) begin
          t   = {r_d, n_d[42]};
          n_d = {n_d[41:0], 1'b0};
          if (t >= {2'b00, den_q[s]}) begin
            t = t - {2'b00, den_q[s]};
            q_d = {q_d[41:0], 1'b1};
          end else begin
            q_d = {q_d[41:0], 1'b0};
          end
          r_d = t[SegW:0];
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        num_q[s+1] <= n_d;
        quo_q[s+1] <= q_d;
        rem_q[s+1] <= r_d;
        den_q[s+1] <= den_q[s];
      end
    end
  end

  assign quo_o = quo_q[NStg];
endmodule
`default_nettype wire

/* rtl/core/uvst_cordic.sv */
// Pipelined 30-step CORDIC: cos and sin in Q30 of a phase in 2^-32 turns
`default_nettype none
module uvst_cordic import uvst_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [31:0] phase_i,
  output logic signed [31:0] cos_o,
  output logic signed [31:0] sin_o
);
  localparam int NPer = 5;
  localparam int NStg = CordSteps / NPer;

  logic signed [35:0] x_q [NStg+1];
  logic signed [35:0] y_q [NStg+1];
  logic signed [33:0] z_q [NStg+1];
  logic               f_q [NStg+1];

  // fold the phase into the right half plane
  always_comb begin
    logic [31:0] p, t;
    t = phase_i + 32'h4000_0000;
    f_q[0] = t[31];
    p = t[31] ? (phase_i ^ 32'h8000_0000) : phase_i;
    z_q[0] = {{2{p[31]}}, p};
    x_q[0] = CordGain;
    y_q[0] = '0;
  end

  for (genvar s = 0; s < NStg; s++) begin : g_stg
    logic signed [35:0] x_d, y_d, dx, dy;
    logic signed [33:0] z_d;
    always_comb begin
      x_d = x_q[s];
      y_d = y_q[s];
      z_d = z_q[s];
      for (int b = 0; b < NPer; b++) begin
        dx = y_d >>> (s * NPer + b);
        dy = x_d >>> (s * NPer + b);
        if (z_d >= 0) begin
          x_d = x_d - dx; y_d = y_d + dy; z_d = z_d - atan_turn(s * NPer + b);
        end else begin
          x_d = x_d + dx; y_d = y_d - dy; z_d = z_d + atan_turn(s * NPer + b);
        end
      end
    end
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[s+1] <= x_d;
        y_q[s+1] <= y_d;
        z_q[s+1] <= z_d;
        f_q[s+1] <= f_q[s];
      end
    end
  end

  // undo the fold and clamp to unit range
  always_comb begin
    logic signed [35:0] x, y;
    x = f_q[NStg] ? -x_q[NStg] : x_q[NStg];
    y = f_q[NStg] ? -y_q[NStg] : y_q[NStg];
    if (x > OneQ30) x = OneQ30; else if (x < -OneQ30) x = -OneQ30;
    if (y > OneQ30) y = OneQ30; else if (y < -OneQ30) y = -OneQ30;
    cos_o = x[31:0];
    sin_o = y[31:0];
  end
endmodule
`default_nettype wire

/* rtl/core/uv_sphere_tessellator.sv */
// Top level: UV sphere vertex and cell triangle generator
//
//  channel | valid       | stall       | payload
//  --------+-------------+-------------+-------------------------------------
//  in      | in_valid_i  | in_stall_o  | command_i, stack_index_i, sector_index_i
//  out     | out_valid_o | out_stall_i | kind_o, comp_a_o..comp_c_o, last_o
//  cfg     | cfg_we_i    | -           | cfg_index_i, cfg_data_i
//
// A vertex gives five results (one per attribute), a cell up to two.
// The input is accepted whenever the pipeline can advance; the serialising
// output stage holds the pipeline until the last result of the tail item
// has transferred. The path from input transfer to first result runs
// through six divider stages, six CORDIC stages and two multiply stages.
// Reset clears the valid bits and loads the register reset values. An output
// stall freezes the whole pipeline in place while the tail item is valid.
`default_nettype none
module uv_sphere_tessellator import uvst_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_index_i,
  input  wire logic [15:0] cfg_data_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic        command_i,
  input  wire logic [10:0] stack_index_i,
  input  wire logic [10:0] sector_index_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [2:0]       kind_o,
  output logic signed [31:0] comp_a_o,
  output logic signed [31:0] comp_b_o,
  output logic signed [31:0] comp_c_o,
  output logic             last_o
);
  localparam int DivLat = 6;
  localparam int CorLat = 6;
  localparam int Lat    = DivLat + CorLat; // stages to CORDIC results

  // configuration registers
  logic [15:0]     rad_q;
  logic [SegW-1:0] sec_reg_q, stk_reg_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_q <= 16'd256; sec_reg_q <= 11'd36; stk_reg_q <= 11'd18;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_index_i))
        REG_RADIUS: rad_q     <= cfg_data_i;
        REG_SECTOR: sec_reg_q <= cfg_data_i[10:0];
        REG_STACK:  stk_reg_q <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  function automatic logic [SegW-1:0] eff(input logic [SegW-1:0] v);
    if (v == '0) return 11'd1;
    if (v > 11'(MaxSeg)) return 11'(MaxSeg);
    return v;
  endfunction

  logic adv;
  // the output stage holds a vertex for five transfers
  logic [2:0] ocnt_q;
  assign in_stall_o = !adv;

  // stage 0: range check
  item_t it0;
  always_comb begin
    it0.cmd = command_i;
    it0.i = stack_index_i;
    it0.j = sector_index_i;
    it0.sec = eff(sec_reg_q);
    it0.stk = eff(stk_reg_q);
    it0.rad = rad_q;
    if (!command_i) it0.err = (stack_index_i > it0.stk) || (sector_index_i > it0.sec);
    else it0.err = (stack_index_i >= it0.stk) || (sector_index_i >= it0.sec);
  end

  // phase dividers
  logic [42:0] q_se, q_st, q_tu, q_tv;
  uvst_divu u_div_se (.clk_i, .en_i(adv),
    .num_i({sector_index_i, 32'd0} + 43'(it0.sec >> 1)), .den_i(it0.sec), .quo_o(q_se));
  uvst_divu u_div_st (.clk_i, .en_i(adv),
    .num_i({1'b0, stack_index_i, 31'd0} + 43'(it0.stk >> 1)), .den_i(it0.stk), .quo_o(q_st));
  // texcoords: (j<<(F+1) + n) / (2n)
  uvst_divu u_div_tu (.clk_i, .en_i(adv),
    .num_i((43'(sector_index_i) << (FracBits + 1)) + 43'(it0.sec) >> 1), .den_i(it0.sec),
    .quo_o(q_tu));
  uvst_divu u_div_tv (.clk_i, .en_i(adv),
    .num_i((43'(stack_index_i) << (FracBits + 1)) + 43'(it0.stk) >> 1), .den_i(it0.stk),
    .quo_o(q_tv));

  // valid bits travel beside the item line
  logic [Lat+1:0] vld_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[Lat:0], in_valid_i};
    end
  end

  // item shift line alongside the datapath
  item_t it_q [Lat+2];
  logic [31:0] tu_q [CorLat+2], tv_q [CorLat+2];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      it_q[0] <= it0;
      for (int k = 1; k < Lat + 2; k++) it_q[k] <= it_q[k-1];
      tu_q[0] <= q_tu[31:0];
      tv_q[0] <= q_tv[31:0];
      for (int k = 1; k < CorLat + 2; k++) begin
        tu_q[k] <= tu_q[k-1]; tv_q[k] <= tv_q[k-1];
      end
    end
  end

  // CORDICs
  logic signed [31:0] cs, ss, ce, se;
  uvst_cordic u_cor_st (.clk_i, .en_i(adv),
    .phase_i(32'h4000_0000 - q_st[31:0]), .cos_o(cs), .sin_o(ss));
  uvst_cordic u_cor_se (.clk_i, .en_i(adv), .phase_i(q_se[31:0]), .cos_o(ce), .sin_o(se));

  // multiply stage 1: products of trig values, R*cs and R*ss
  logic signed [63:0] p_cce, p_cse, p_sce, p_sse;
  logic signed [49:0] p_rc, p_rs;
  logic signed [31:0] cs1, ss1, ce1, se1;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_cce <= cs * ce; p_cse <= cs * se; p_sce <= ss * ce; p_sse <= ss * se;
      p_rc  <= $signed({1'b0, it_q[Lat-1].rad}) * cs;
      p_rs  <= $signed({1'b0, it_q[Lat-1].rad}) * ss;
      cs1 <= cs; ss1 <= ss; ce1 <= ce; se1 <= se;
    end
  end
  // multiply stage 2: xy times sector terms (xy fits 34 signed bits)
  logic signed [71:0] xy;
  assign xy = rnd(72'(p_rc), 14);
  logic signed [71:0] p_x, p_y;
  logic [31:0] r_q [2:14];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_x <= $signed(xy[33:0]) * ce1;
      p_y <= $signed(xy[33:0]) * se1;
      r_q[2]  <= sat32(rnd(72'(p_rs), 38 - FracBits));
      r_q[3]  <= sat32(rnd(72'(p_cce), 60 - FracBits));
      r_q[4]  <= sat32(rnd(72'(p_cse), 60 - FracBits));
      r_q[5]  <= sat32(rnd(72'(ss1), 30 - FracBits));
      r_q[6]  <= tu_q[CorLat];
      r_q[7]  <= tv_q[CorLat];
      r_q[8]  <= 32'd0;
      r_q[9]  <= sat32(rnd(-72'(se1), 30 - FracBits));
      r_q[10] <= sat32(rnd(72'(ce1), 30 - FracBits));
      r_q[11] <= 32'd0;
      r_q[12] <= sat32(rnd(-72'(p_sce), 60 - FracBits));
      r_q[13] <= sat32(rnd(-72'(p_sse), 60 - FracBits));
      r_q[14] <= sat32(rnd(72'(cs1), 30 - FracBits));
    end
  end
  logic [31:0] pos_x, pos_y;
  always_comb begin
    pos_x = sat32(rnd(p_x, 54 - FracBits));
    pos_y = sat32(rnd(p_y, 54 - FracBits));
  end

  // triangle indices, computed at the tail stage
  item_t tl;
  assign tl = it_q[Lat+1];
  logic [31:0] k1, k2;
  logic first, second;
  always_comb begin
    k1 = 32'(tl.i) * 32'({1'b0, tl.sec} + 12'd1) + 32'(tl.j);
    k2 = k1 + 32'(tl.sec) + 32'd1;
    first = tl.i != '0;
    second = tl.i != tl.stk - 11'd1;
  end

  // number of results of the tail item
  logic [2:0] nres;
  always_comb begin
    if (!vld_q[Lat+1]) nres = 3'd0;
    else if (tl.err) nres = 3'd1;
    else if (!tl.cmd) nres = 3'd5;
    else nres = 3'(first) + 3'(second);
  end

  // output stage: serialise results of the tail item
  logic [2:0] sel;
  assign sel = ocnt_q;
  logic done;
  assign done = (nres == 3'd0) || (!out_stall_i && (ocnt_q == nres - 3'd1));
  assign adv = done;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ocnt_q <= '0;
    end else if (done) begin
      ocnt_q <= '0;
    end else if (!out_stall_i) begin
      ocnt_q <= ocnt_q + 3'd1;
    end
  end

  always_comb begin
    out_valid_o = nres != 3'd0;
    last_o = ocnt_q == nres - 3'd1;
    kind_o = KIND_ERR; comp_a_o = '0; comp_b_o = '0; comp_c_o = '0;
    if (tl.err) begin
      kind_o = KIND_ERR;
    end else if (tl.cmd) begin
      kind_o = KIND_TRI;
      if (first && sel == 3'd0) begin
        comp_a_o = k1; comp_b_o = k2; comp_c_o = k1 + 32'd1;
      end else begin
        comp_a_o = k1 + 32'd1; comp_b_o = k2; comp_c_o = k2 + 32'd1;
      end
    end else begin
      kind_o = 3'(sel);
      case (kind_e'(sel))
        KIND_POS: begin
          comp_a_o = pos_x; comp_b_o = pos_y; comp_c_o = r_q[2];
        end
        KIND_NRM: begin
          comp_a_o = r_q[3]; comp_b_o = r_q[4]; comp_c_o = r_q[5];
        end
        KIND_TEX: begin
          comp_a_o = r_q[6]; comp_b_o = r_q[7]; comp_c_o = r_q[8];
        end
        KIND_TAN: begin
          comp_a_o = r_q[9]; comp_b_o = r_q[10]; comp_c_o = r_q[11];
        end
        KIND_BIT: begin
          comp_a_o = r_q[12]; comp_b_o = r_q[13]; comp_c_o = r_q[14];
        end
        default: ;
      endcase
    end
  end
endmodule
`default_nettype wire

/* bench/tb.sv */
// Testbench for the UV sphere tessellator: directed table, random traffic, scoreboard
`timescale 1ns / 1ps
`default_nettype none
module tb;
  import uvst_pkg::*;

  localparam int Fb = 16;
  localparam int MaxSegments = 1024;
  localparam int WatchLimit = 20000;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic        last;
  } result_t;

  typedef struct {
    logic        cmd;
    logic [10:0] i;
    logic [10:0] j;
    logic        typed;   // expected result written into the row
    result_t     res;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = REG_RADIUS;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        command_i = 1'b0;
  logic [10:0] stack_index_i = '0;
  logic [10:0] sector_index_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  kind_o;
  logic signed [31:0] comp_a_o, comp_b_o, comp_c_o;
  logic        last_o;

  uv_sphere_tessellator uut (.*);

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // shadow copy of the configuration registers
  logic [15:0] sh_radius = 16'd256;
  logic [10:0] sh_sectors = 11'd36;
  logic [10:0] sh_stacks = 11'd18;

  result_t expected_q[$];
  int      n_fail = 0;
  int      n_results = 0;
  int      n_vertex = 0;
  int      n_cell = 0;
  int      n_err = 0;
  int      idle_cycles = 0;
  int      stall_left = 0;
  bit      timed_out = 1'b0;
  bit      sender_done = 1'b0;

  // append one expectation to the scoreboard
  function automatic void expect_result(result_t r);
    expected_q.insert(expected_q.size(), r);
  endfunction

  function automatic longint asr_s(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint round_sh(longint v, int s);
    return (v + (64'sd1 <<< (s - 1))) >>> s;
  endfunction

  function automatic logic [31:0] clip32(longint v);
    if (v > 64'sd2147483647) return 32'h7fff_ffff;
    if (v < -64'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

  function automatic longint clip_q30(longint v);
    if (v > 64'sd1073741824) return 64'sd1073741824;
    if (v < -64'sd1073741824) return -64'sd1073741824;
    return v;
  endfunction

  function automatic longint arc_step(int k);
    longint t[30] = '{536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
                      10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
                      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163,
                      81, 41, 20, 10, 5, 3, 1};
    return t[k];
  endfunction

  // cos and sin in Q30 of a phase in 2^-32 turns
  task automatic rotate(input logic [31:0] phase, output longint c, output longint s);
    logic [31:0] sum, p;
    bit     flip;
    longint x, y, z, dx, dy;
    sum = phase + 32'h4000_0000;
    flip = sum[31];
    p = flip ? (phase ^ 32'h8000_0000) : phase;
    z = p[31] ? longint'(p) - (64'sd1 <<< 32) : longint'(p);
    x = 64'sd652032874;
    y = 0;
    for (int k = 0; k < 30; k++) begin
      dx = asr_s(y, k);
      dy = asr_s(x, k);
      if (z >= 0) begin
        x -= dx; y += dy; z -= arc_step(k);
      end else begin
        x += dx; y -= dy; z += arc_step(k);
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    c = clip_q30(x);
    s = clip_q30(y);
  endtask

  function automatic longint eff_segments(logic [10:0] v);
    if (v == 0) return 1;
    if (v > MaxSegments) return MaxSegments;
    return v;
  endfunction

  function automatic result_t mk(logic [2:0] k, longint a, longint b, longint c,
                                 logic l);
    result_t r;
    r.kind = k; r.a = clip32(a); r.b = clip32(b); r.c = clip32(c); r.last = l;
    return r;
  endfunction

  // expected results of one accepted item, appended to the queue
  task automatic predict_mesh(input logic cmd, input logic [10:0] i, input logic [10:0] j);
    longint sec, stk, cs, ss, ce, se, rr, xy, k1, k2, li, lj;
    logic [31:0] ph_se, ph_st;
    logic [63:0] num;
    sec = eff_segments(sh_sectors);
    stk = eff_segments(sh_stacks);
    li = i; lj = j;
    if (cmd == 1'b0) begin
      if (li > stk || lj > sec) begin
        expect_result(mk(KIND_ERR, 0, 0, 0, 1'b1));
        return;
      end
      num = ((64'(lj) << 32) + sec / 2) / sec;
      ph_se = num[31:0];
      num = ((64'(li) << 31) + stk / 2) / stk;
      ph_st = 32'h4000_0000 - num[31:0];
      rotate(ph_st, cs, ss);
      rotate(ph_se, ce, se);
      rr = sh_radius;
      xy = round_sh(rr * cs, 14);
      expect_result(mk(KIND_POS, round_sh(xy * ce, 54 - Fb),
                       round_sh(xy * se, 54 - Fb), round_sh(rr * ss, 38 - Fb), 1'b0));
      expect_result(mk(KIND_NRM, round_sh(cs * ce, 60 - Fb),
                       round_sh(cs * se, 60 - Fb), round_sh(ss, 30 - Fb), 1'b0));
      expect_result(mk(KIND_TEX, ((lj << (Fb + 1)) + sec) / (2 * sec),
                       ((li << (Fb + 1)) + stk) / (2 * stk), 0, 1'b0));
      expect_result(mk(KIND_TAN, round_sh(-se, 30 - Fb), round_sh(ce, 30 - Fb),
                       0, 1'b0));
      expect_result(mk(KIND_BIT, round_sh(-(ss * ce), 60 - Fb),
                       round_sh(-(ss * se), 60 - Fb), round_sh(cs, 30 - Fb), 1'b1));
    end else begin
      if (li >= stk || lj >= sec) begin
        expect_result(mk(KIND_ERR, 0, 0, 0, 1'b1));
        return;
      end
      k1 = li * (sec + 1) + lj;
      k2 = k1 + sec + 1;
      if (li != 0)
        expect_result(mk(KIND_TRI, k1, k2, k1 + 1, li == stk - 1));
      if (li != stk - 1)
        expect_result(mk(KIND_TRI, k1 + 1, k2, k2 + 1, 1'b1));
    end
  endtask

  task automatic wait_cycles(int n);
    repeat (n) @(posedge clk_i);
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // one input transfer, then an optional gap
  task automatic send_item(input logic cmd, input logic [10:0] i, input logic [10:0] j,
                           input int gap);
    in_valid_i <= 1'b1;
    command_i <= cmd;
    stack_index_i <= i;
    sector_index_i <= j;
    do @(posedge clk_i); while (in_stall_o);
    predict_mesh(cmd, i, j);
    if (cmd) n_cell++; else n_vertex++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      wait_cycles(gap);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0 && !timed_out) @(posedge clk_i);
    wait_cycles(20);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [15:0] val);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_RADIUS: sh_radius = val;
      REG_SECTOR: sh_sectors = val[10:0];
      REG_STACK:  sh_stacks = val[10:0];
      default: ;
    endcase
  endtask

  // random index, mostly in range
  function automatic logic [10:0] pick_idx(longint lim);
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return 11'($urandom_range(0, int'(lim)));
    if (r < 90) return lim[10:0];
    return 11'($urandom_range(0, 2047));
  endfunction

  // output side: stall bursts of random length, compare each transfer in order
  always @(posedge clk_i) begin
    result_t e;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        n_results++;
        if (expected_q.size() == 0) begin
          n_fail++;
          if (n_fail <= 10)
            $display("unexpected result kind=%0d a=%h b=%h c=%h last=%b",
                     kind_o, comp_a_o, comp_b_o, comp_c_o, last_o);
        end else begin
          e = expected_q.pop_front();
          if (e.kind == KIND_ERR) n_err++;
          if (kind_o !== e.kind || comp_a_o !== e.a || comp_b_o !== e.b ||
              comp_c_o !== e.c || last_o !== e.last) begin
            n_fail++;
            if (n_fail <= 10)
              $display("mismatch: exp kind=%0d a=%h b=%h c=%h last=%b, got kind=%0d a=%h b=%h c=%h last=%b",
                       e.kind, e.a, e.b, e.c, e.last,
                       kind_o, comp_a_o, comp_b_o, comp_c_o, last_o);
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else if (!sender_done && $urandom_range(0, 99) < 20) begin
        stall_left = gap_len();
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WatchLimit) begin
      timed_out = 1'b1;
      $display("TB_ERROR");
      $finish;
    end
  end

  stim_row_t dir_rows[$];

  task automatic add_row(logic cmd, logic [10:0] i, logic [10:0] j, bit typed,
                         result_t r);
    stim_row_t s;
    s.cmd = cmd; s.i = i; s.j = j; s.typed = typed; s.res = r;
    dir_rows.insert(dir_rows.size(), s);
  endtask

  initial begin
    result_t none, err_r, tri_top;
    longint sec, stk;
    int n_rand;
    none = mk(KIND_ERR, 0, 0, 0, 1'b1);
    err_r = mk(KIND_ERR, 0, 0, 0, 1'b1);
    // reset config: north pole cell gives only the lower triangle
    tri_top = mk(KIND_TRI, 1, 37, 38, 1'b1);

    // directed table at reset configuration
    add_row(1'b1, 11'd0, 11'd0, 1'b1, tri_top);
    add_row(1'b0, 11'd0, 11'd0, 1'b0, none);
    add_row(1'b0, 11'd18, 11'd36, 1'b0, none);
    add_row(1'b0, 11'd9, 11'd9, 1'b0, none);
    add_row(1'b0, 11'd19, 11'd0, 1'b1, err_r);
    add_row(1'b0, 11'd0, 11'd37, 1'b1, err_r);
    add_row(1'b0, 11'h7ff, 11'h7ff, 1'b1, err_r);
    add_row(1'b1, 11'd18, 11'd0, 1'b1, err_r);
    add_row(1'b1, 11'd0, 11'd36, 1'b1, err_r);
    add_row(1'b1, 11'd17, 11'd35, 1'b0, none);
    add_row(1'b1, 11'd5, 11'd7, 1'b0, none);
    add_row(1'b0, 11'd4, 11'd27, 1'b0, none);
    add_row(1'b0, 11'd13, 11'd18, 1'b0, none);
    add_row(1'b1, 11'h400, 11'h3ff, 1'b1, err_r);

    wait_cycles(11);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].typed) begin
        send_item(dir_rows[k].cmd, dir_rows[k].i, dir_rows[k].j, 0);
        // replace the predicted single result with the typed one
        void'(expected_q.pop_back());
        expect_result(dir_rows[k].res);
      end else
        send_item(dir_rows[k].cmd, dir_rows[k].i, dir_rows[k].j, gap_len());
    end
    drain();

    // phases of configuration, extremes among them, then random traffic
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: begin write_reg(REG_RADIUS, 16'hffff); write_reg(REG_SECTOR, 16'd1);
                 write_reg(REG_STACK, 16'd1); end
        1: begin write_reg(REG_RADIUS, 16'd1); write_reg(REG_SECTOR, 16'd1024);
                 write_reg(REG_STACK, 16'd1024); end
        2: begin write_reg(REG_RADIUS, 16'h8000); write_reg(REG_SECTOR, 16'd0);
                 write_reg(REG_STACK, 16'd0); end
        3: begin write_reg(REG_RADIUS, 16'hffff); write_reg(REG_SECTOR, 16'h7ff);
                 write_reg(REG_STACK, 16'h5aa); end
        4: begin write_reg(REG_RADIUS, 16'd256); write_reg(REG_SECTOR, 16'd4);
                 write_reg(REG_STACK, 16'd2); end
        default: begin
          write_reg(REG_RADIUS, 16'($urandom_range(1, 65535)));
          write_reg(REG_SECTOR, 16'($urandom_range(1, 40)));
          write_reg(REG_STACK, 16'($urandom_range(1, 40)));
        end
      endcase
      sec = eff_segments(sh_sectors);
      stk = eff_segments(sh_stacks);
      n_rand = 50;
      for (int k = 0; k < n_rand; k++) begin
        logic cmd;
        cmd = 1'($urandom_range(0, 1));
        // long stretch without sender gaps in the middle of each phase
        send_item(cmd, pick_idx(cmd ? stk : stk + 1), pick_idx(cmd ? sec : sec + 1),
                  (k > 15 && k < 30) ? 0 : gap_len());
        // pause the sender until everything in flight has come back
        if (k == 35) begin
          in_valid_i <= 1'b0;
          while (expected_q.size() != 0) @(posedge clk_i);
        end
      end
      drain();
    end

    sender_done = 1'b1;
    drain();
    $display("covered %0d vertex and %0d cell requests, %0d results (%0d index errors)",
             n_vertex, n_cell, n_results, n_err);
    $display("configurations included unit/max radius and zero, one, max and oversized counts");
    if (n_fail == 0 && expected_q.size() == 0)
      $display("TB_OK");
    else begin
      $display("%0d failures, %0d expectations left", n_fail, expected_q.size());
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
rtl/core/uvst_pkg.sv
rtl/core/uvst_divu.sv
rtl/core/uvst_cordic.sv
rtl/core/uv_sphere_tessellator.sv
bench/tb.sv
